[src/clkam_pkg.sv]
// Package with the shared types, mode codes and wrap helpers of the clock mode controller.
`timescale 1ns / 1ps
`default_nettype none

package clkam_pkg;

	// Field widths.
	localparam int unsigned HourW   = 5;
	localparam int unsigned MinuteW = 6;
	localparam int unsigned ModeW   = 4;

	// Stream widths, padded to whole bytes.
	localparam int unsigned InDataW  = 32;
	localparam int unsigned OutDataW = 48;

	// Wrap limits of the hour and minute counters.
	localparam logic [HourW-1:0]   HOUR_MAX   = 5'd23;
	localparam logic [MinuteW-1:0] MINUTE_MAX = 6'd59;

	// Mode codes.
	localparam logic [ModeW-1:0] MODE_INIT       = 4'd0;
	localparam logic [ModeW-1:0] MODE_CLOCK      = 4'd1;
	localparam logic [ModeW-1:0] MODE_ALARM      = 4'd2;
	localparam logic [ModeW-1:0] MODE_ALARM_HOUR = 4'd3;
	localparam logic [ModeW-1:0] MODE_ALARM_MIN  = 4'd4;
	localparam logic [ModeW-1:0] MODE_CD         = 4'd5;
	localparam logic [ModeW-1:0] MODE_CD_HOUR    = 4'd6;
	localparam logic [ModeW-1:0] MODE_CD_MIN     = 4'd7;
	localparam logic [ModeW-1:0] MODE_CD_RUN     = 4'd8;
	localparam logic [ModeW-1:0] MODE_TIME       = 4'd9;
	localparam logic [ModeW-1:0] MODE_TIME_HOUR  = 4'd10;
	localparam logic [ModeW-1:0] MODE_TIME_MIN   = 4'd11;

	// One poll item.
	typedef struct packed {
		logic               press_mode;
		logic               press_set;
		logic               press_up;
		logic               press_down;
		logic               blink_red_due;
		logic               blink_yellow_due;
		logic               blink_green_due;
		logic               countdown_tick;
		logic [HourW-1:0]   now_hour;
		logic [MinuteW-1:0] now_minute;
		logic [MinuteW-1:0] now_second;
	} item_t;

	// Controller state carried from one item to the next.
	typedef struct packed {
		logic [ModeW-1:0]   mode;
		logic [HourW-1:0]   edit_hours;
		logic [MinuteW-1:0] edit_minutes;
		logic [MinuteW-1:0] shown_left;
		logic [MinuteW-1:0] shown_right;
		logic [HourW-1:0]   alarm_hours;
		logic [MinuteW-1:0] alarm_minutes;
		logic [HourW-1:0]   preset_hours;
		logic [MinuteW-1:0] preset_minutes;
	} state_t;

	// One result item.
	typedef struct packed {
		logic [ModeW-1:0]   mode_code;
		logic [MinuteW-1:0] display_left;
		logic [MinuteW-1:0] display_right;
		logic               toggle_red;
		logic               toggle_yellow;
		logic               toggle_green;
		logic               time_write_hour;
		logic               time_write_minute;
		logic [HourW-1:0]   new_hour;
		logic [MinuteW-1:0] new_minute;
		logic [HourW-1:0]   alarm_hour_out;
		logic [MinuteW-1:0] alarm_minute_out;
	} result_t;

	// Hour up: anything at or above the limit wraps to zero.
	function automatic logic [HourW-1:0] hour_up(input logic [HourW-1:0] h);
		return (h >= HOUR_MAX) ? '0 : h + 5'd1;
	endfunction

	// Hour down: zero wraps to the limit.
	function automatic logic [HourW-1:0] hour_down(input logic [HourW-1:0] h);
		return (h == '0) ? HOUR_MAX : h - 5'd1;
	endfunction

	// Minute up: anything at or above the limit wraps to zero.
	function automatic logic [MinuteW-1:0] minute_up(input logic [MinuteW-1:0] m);
		return (m >= MINUTE_MAX) ? '0 : m + 6'd1;
	endfunction

	// Minute down: zero wraps to the limit.
	function automatic logic [MinuteW-1:0] minute_down(input logic [MinuteW-1:0] m);
		return (m == '0) ? MINUTE_MAX : m - 6'd1;
	endfunction

endpackage

`default_nettype wire

[src/clkam_step.sv]
// Next-state and result logic of the clock mode controller for one poll item.
`timescale 1ns / 1ps
`default_nettype none

module clkam_step (
	input  wire clkam_pkg::state_t cur,
	input  wire clkam_pkg::item_t  item,
	output clkam_pkg::state_t  nxt,
	output clkam_pkg::result_t res
);

	clkam_pkg::state_t         st;
	logic                      tog_r;
	logic                      tog_y;
	logic                      tog_g;
	logic                      wr_h;
	logic                      wr_m;
	logic [clkam_pkg::HourW-1:0]   val_h;
	logic [clkam_pkg::MinuteW-1:0] val_m;

	// Checks of the current mode run in order; a later one overrides an earlier one.
	always_comb begin
		st    = cur;
		tog_r = 1'b0;
		tog_y = 1'b0;
		tog_g = 1'b0;
		wr_h  = 1'b0;
		wr_m  = 1'b0;
		val_h = '0;
		val_m = '0;

		case (cur.mode)
			clkam_pkg::MODE_INIT: begin
				st.mode = clkam_pkg::MODE_CLOCK;
			end
			clkam_pkg::MODE_CLOCK: begin
				st.shown_left  = item.now_minute;
				st.shown_right = item.now_second;
				if (item.press_mode) begin
					st.mode         = clkam_pkg::MODE_ALARM;
					st.edit_hours   = cur.alarm_hours;
					st.edit_minutes = cur.alarm_minutes;
					st.shown_left   = {1'b0, cur.alarm_hours};
					st.shown_right  = cur.alarm_minutes;
				end
				tog_r = item.blink_red_due;
			end
			clkam_pkg::MODE_ALARM: begin
				if (item.press_mode) begin
					st.mode         = clkam_pkg::MODE_CD;
					st.edit_hours   = cur.preset_hours;
					st.edit_minutes = cur.preset_minutes;
					st.shown_left   = {1'b0, cur.preset_hours};
					st.shown_right  = cur.preset_minutes;
				end
				// Set loads the alarm for editing but leaves the display alone.
				if (item.press_set) begin
					st.mode         = clkam_pkg::MODE_ALARM_HOUR;
					st.edit_hours   = cur.alarm_hours;
					st.edit_minutes = cur.alarm_minutes;
				end
				tog_y = item.blink_yellow_due;
			end
			clkam_pkg::MODE_ALARM_HOUR, clkam_pkg::MODE_CD_HOUR,
			clkam_pkg::MODE_TIME_HOUR: begin
				if (item.press_mode) begin
					st.mode = (cur.mode == clkam_pkg::MODE_ALARM_HOUR) ? clkam_pkg::MODE_CD :
						(cur.mode == clkam_pkg::MODE_CD_HOUR) ? clkam_pkg::MODE_TIME :
						clkam_pkg::MODE_CLOCK;
				end
				if (item.press_up) begin
					st.edit_hours = clkam_pkg::hour_up(st.edit_hours);
				end
				if (item.press_down) begin
					st.edit_hours = clkam_pkg::hour_down(st.edit_hours);
				end
				if (item.press_up || item.press_down) begin
					st.shown_left  = {1'b0, st.edit_hours};
					st.shown_right = st.edit_minutes;
				end
				// Set commits the hour and moves on to minute editing.
				if (item.press_set) begin
					if (cur.mode == clkam_pkg::MODE_ALARM_HOUR) begin
						st.alarm_hours = st.edit_hours;
						st.mode        = clkam_pkg::MODE_ALARM_MIN;
					end else if (cur.mode == clkam_pkg::MODE_CD_HOUR) begin
						st.preset_hours = st.edit_hours;
						st.mode         = clkam_pkg::MODE_CD_MIN;
					end else begin
						wr_h    = 1'b1;
						val_h   = st.edit_hours;
						st.mode = clkam_pkg::MODE_TIME_MIN;
					end
				end
				tog_g = (cur.mode == clkam_pkg::MODE_ALARM_HOUR) && item.blink_green_due;
			end
			clkam_pkg::MODE_ALARM_MIN, clkam_pkg::MODE_CD_MIN,
			clkam_pkg::MODE_TIME_MIN: begin
				if (item.press_mode) begin
					st.mode = (cur.mode == clkam_pkg::MODE_ALARM_MIN) ? clkam_pkg::MODE_CD :
						(cur.mode == clkam_pkg::MODE_CD_MIN) ? clkam_pkg::MODE_TIME :
						clkam_pkg::MODE_CLOCK;
				end
				if (item.press_up) begin
					st.edit_minutes = clkam_pkg::minute_up(st.edit_minutes);
				end
				if (item.press_down) begin
					st.edit_minutes = clkam_pkg::minute_down(st.edit_minutes);
				end
				if (item.press_up || item.press_down) begin
					st.shown_left  = {1'b0, st.edit_hours};
					st.shown_right = st.edit_minutes;
				end
				// Set commits the minute and returns to the view with the hour reloaded.
				if (item.press_set) begin
					if (cur.mode == clkam_pkg::MODE_ALARM_MIN) begin
						st.alarm_minutes = st.edit_minutes;
						st.mode          = clkam_pkg::MODE_ALARM;
						st.edit_hours    = st.alarm_hours;
					end else if (cur.mode == clkam_pkg::MODE_CD_MIN) begin
						st.preset_minutes = st.edit_minutes;
						st.mode           = clkam_pkg::MODE_CD;
						st.edit_hours     = st.preset_hours;
					end else begin
						wr_m          = 1'b1;
						val_m         = st.edit_minutes;
						st.mode       = clkam_pkg::MODE_TIME;
						st.edit_hours = item.now_hour;
					end
					st.shown_left  = {1'b0, st.edit_hours};
					st.shown_right = st.edit_minutes;
				end
			end
			clkam_pkg::MODE_CD: begin
				if (item.press_mode) begin
					st.mode         = clkam_pkg::MODE_TIME;
					st.edit_hours   = item.now_hour;
					st.edit_minutes = item.now_minute;
				end
				if (item.press_set || (item.press_up && item.press_down)) begin
					st.mode         = (item.press_up && item.press_down) ?
						clkam_pkg::MODE_CD_RUN : clkam_pkg::MODE_CD_HOUR;
					st.edit_hours   = cur.preset_hours;
					st.edit_minutes = cur.preset_minutes;
				end
				if (item.press_mode || item.press_set || (item.press_up && item.press_down)) begin
					st.shown_left  = {1'b0, st.edit_hours};
					st.shown_right = st.edit_minutes;
				end
			end
			clkam_pkg::MODE_CD_RUN: begin
				// Count down one minute per tick, borrowing an hour at zero minutes.
				if (item.countdown_tick) begin
					if (cur.edit_minutes != '0) begin
						st.edit_minutes = cur.edit_minutes - 6'd1;
					end else if (cur.edit_hours != '0) begin
						st.edit_hours   = cur.edit_hours - 5'd1;
						st.edit_minutes = clkam_pkg::MINUTE_MAX;
					end
					st.shown_left  = {1'b0, st.edit_hours};
					st.shown_right = st.edit_minutes;
				end
				if (item.press_mode) begin
					st.mode = clkam_pkg::MODE_TIME;
				end
				if (item.press_set) begin
					st.preset_hours = st.edit_hours;
					st.mode         = clkam_pkg::MODE_CD_HOUR;
				end
			end
			clkam_pkg::MODE_TIME: begin
				if (item.press_mode) begin
					st.mode         = clkam_pkg::MODE_CLOCK;
					st.edit_hours   = item.now_hour;
					st.edit_minutes = item.now_minute;
					st.shown_left   = {1'b0, item.now_hour};
					st.shown_right  = item.now_minute;
				end
				if (item.press_set) begin
					st.mode = clkam_pkg::MODE_TIME_HOUR;
				end
			end
			default: begin
				st = cur;
			end
		endcase
	end

	// Result fields follow from the state after the step.
	always_comb begin
		nxt                   = st;
		res.mode_code         = st.mode;
		res.display_left      = st.shown_left;
		res.display_right     = st.shown_right;
		res.toggle_red        = tog_r;
		res.toggle_yellow     = tog_y;
		res.toggle_green      = tog_g;
		res.time_write_hour   = wr_h;
		res.time_write_minute = wr_m;
		res.new_hour          = val_h;
		res.new_minute        = val_m;
		res.alarm_hour_out    = st.alarm_hours;
		res.alarm_minute_out  = st.alarm_minutes;
	end

endmodule

`default_nettype wire

[src/clock_alarm_countdown_mode_fsm.sv]
// Top level of the clock mode controller: input register, state, step logic and result register.
// A poll item goes through the input register, the step logic and then the result register.
// Throughput: one item per cycle unless the output stalls; the step logic is combinational.
// Backpressure on the output stalls the two register stages, a full pipe drops s_axis_tready.
// Reset: arst_n clears both stage valids and all state to zero (init mode, all presets zero).
`timescale 1ns / 1ps
`default_nettype none

module clock_alarm_countdown_mode_fsm (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// Bits from 0: press_mode, press_set, press_up, press_down, blink_red_due,
	// blink_yellow_due, blink_green_due, countdown_tick, now_hour[12:8],
	// now_minute[18:13], now_second[24:19], zero fill.
	input  wire logic [clkam_pkg::InDataW-1:0]      s_axis_tdata,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// Bits from 0: mode_code[3:0], display_left[9:4], display_right[15:10], toggle_red,
	// toggle_yellow, toggle_green, time_write_hour, time_write_minute, new_hour[25:21],
	// new_minute[31:26], alarm_hour_out[36:32], alarm_minute_out[42:37], zero fill.
	output logic [clkam_pkg::OutDataW-1:0]          m_axis_tdata
);

	clkam_pkg::item_t   item_s1;
	logic               valid_s1;
	clkam_pkg::result_t res_s2;
	logic               valid_s2;
	clkam_pkg::state_t  state_q;
	clkam_pkg::state_t  state_nxt;
	clkam_pkg::result_t res_nxt;
	clkam_pkg::item_t   item_in;
	logic               adv_s2;
	logic               take_in;

	// Unpack the incoming item.
	assign item_in.press_mode       = s_axis_tdata[0];
	assign item_in.press_set        = s_axis_tdata[1];
	assign item_in.press_up         = s_axis_tdata[2];
	assign item_in.press_down       = s_axis_tdata[3];
	assign item_in.blink_red_due    = s_axis_tdata[4];
	assign item_in.blink_yellow_due = s_axis_tdata[5];
	assign item_in.blink_green_due  = s_axis_tdata[6];
	assign item_in.countdown_tick   = s_axis_tdata[7];
	assign item_in.now_hour         = s_axis_tdata[12:8];
	assign item_in.now_minute       = s_axis_tdata[18:13];
	assign item_in.now_second       = s_axis_tdata[24:19];

	// Stage two moves when the result register is free or drained this cycle.
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_s2;
	assign take_in       = s_axis_tvalid && s_axis_tready;

	clkam_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Pipeline valids and controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					state_q <= state_nxt;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= item_in;
		end
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_nxt;
		end
	end

	// Pack the result item.
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {5'd0, res_s2.alarm_minute_out, res_s2.alarm_hour_out,
		res_s2.new_minute, res_s2.new_hour, res_s2.time_write_minute,
		res_s2.time_write_hour, res_s2.toggle_green, res_s2.toggle_yellow,
		res_s2.toggle_red, res_s2.display_right, res_s2.display_left, res_s2.mode_code};

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the clock mode controller: directed table, random polls, scoreboard.
`timescale 1ns / 1ps

module testbench;
	import clkam_pkg::*;

	// Button and tick masks used to write the directed table.
	localparam logic [3:0] B_NONE = 4'b0000;
	localparam logic [3:0] B_MODE = 4'b0001;
	localparam logic [3:0] B_SET  = 4'b0010;
	localparam logic [3:0] B_UP   = 4'b0100;
	localparam logic [3:0] B_DOWN = 4'b1000;
	localparam logic [3:0] D_NONE = 4'b0000;
	localparam logic [3:0] D_RED  = 4'b0001;
	localparam logic [3:0] D_YEL  = 4'b0010;
	localparam logic [3:0] D_GRE  = 4'b0100;
	localparam logic [3:0] D_TICK = 4'b1000;

	localparam int RANDOM_POLLS = 1820;
	localparam int IDLE_PCT     = 36;
	localparam int STALL_LIMIT  = 2000;

	// One row of the directed table; want is used only where typed is set.
	typedef struct {
		item_t   poll;
		bit      typed;
		result_t want;
	} row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	wire logic           s_axis_tready;
	// Bits from 0: press_mode, press_set, press_up, press_down, blink_red_due,
	// blink_yellow_due, blink_green_due, countdown_tick, now_hour[12:8],
	// now_minute[18:13], now_second[24:19], zero fill.
	logic [InDataW-1:0]  s_axis_tdata = '0;
	wire logic           m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	// Bits from 0: mode_code[3:0], display_left[9:4], display_right[15:10], toggle_red,
	// toggle_yellow, toggle_green, time_write_hour, time_write_minute, new_hour[25:21],
	// new_minute[31:26], alarm_hour_out[36:32], alarm_minute_out[42:37], zero fill.
	wire logic [OutDataW-1:0] m_axis_tdata;

	state_t   clock_ctl;
	result_t  poll_answers[$];
	row_t     plan[$];
	int       n_errors = 0;
	int       idle_cycles = 0;
	bit       steady = 1'b0;

	clock_alarm_countdown_mode_fsm u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #4 clk = ~clk;

	// Build one poll item from button and tick masks and the time of day.
	function automatic item_t poll(input logic [3:0] btn, input logic [3:0] due,
			input logic [4:0] h, input logic [5:0] m, input logic [5:0] s);
		item_t p;
		p.press_mode       = btn[0];
		p.press_set        = btn[1];
		p.press_up         = btn[2];
		p.press_down       = btn[3];
		p.blink_red_due    = due[0];
		p.blink_yellow_due = due[1];
		p.blink_green_due  = due[2];
		p.countdown_tick   = due[3];
		p.now_hour         = h;
		p.now_minute       = m;
		p.now_second       = s;
		return p;
	endfunction

	// A result with the given view, display and alarm, the red toggle, and all strobes low.
	function automatic result_t shown(input logic [3:0] mode, input logic [5:0] left,
			input logic [5:0] right, input logic [4:0] ah, input logic [5:0] am,
			input logic red);
		result_t r;
		r                  = '0;
		r.mode_code        = mode;
		r.display_left     = left;
		r.display_right    = right;
		r.alarm_hour_out   = ah;
		r.alarm_minute_out = am;
		r.toggle_red       = red;
		return r;
	endfunction

	function automatic logic [InDataW-1:0] pack_poll(input item_t p);
		logic [InDataW-1:0] d;
		d        = '0;
		d[0]     = p.press_mode;
		d[1]     = p.press_set;
		d[2]     = p.press_up;
		d[3]     = p.press_down;
		d[4]     = p.blink_red_due;
		d[5]     = p.blink_yellow_due;
		d[6]     = p.blink_green_due;
		d[7]     = p.countdown_tick;
		d[12:8]  = p.now_hour;
		d[18:13] = p.now_minute;
		d[24:19] = p.now_second;
		return d;
	endfunction

	function automatic result_t unpack_answer(input logic [OutDataW-1:0] d);
		result_t r;
		r.mode_code         = d[3:0];
		r.display_left      = d[9:4];
		r.display_right     = d[15:10];
		r.toggle_red        = d[16];
		r.toggle_yellow     = d[17];
		r.toggle_green      = d[18];
		r.time_write_hour   = d[19];
		r.time_write_minute = d[20];
		r.new_hour          = d[25:21];
		r.new_minute        = d[31:26];
		r.alarm_hour_out    = d[36:32];
		r.alarm_minute_out  = d[42:37];
		return r;
	endfunction

	// The display follows the edited pair.
	function automatic void mirror_edit();
		clock_ctl.shown_left  = {1'b0, clock_ctl.edit_hours};
		clock_ctl.shown_right = clock_ctl.edit_minutes;
	endfunction

	function automatic void load_edit(input logic [4:0] h, input logic [5:0] m);
		clock_ctl.edit_hours   = h;
		clock_ctl.edit_minutes = m;
	endfunction

	// Hour editing: up wraps anything at or above the limit to zero, down wraps zero up.
	function automatic void hour_buttons(input logic up, input logic down);
		if (up) begin
			clock_ctl.edit_hours = (clock_ctl.edit_hours >= HOUR_MAX) ? 5'd0
				: clock_ctl.edit_hours + 5'd1;
			mirror_edit();
		end
		if (down) begin
			clock_ctl.edit_hours = (clock_ctl.edit_hours == 5'd0) ? HOUR_MAX
				: clock_ctl.edit_hours - 5'd1;
			mirror_edit();
		end
	endfunction

	function automatic void minute_buttons(input logic up, input logic down);
		if (up) begin
			clock_ctl.edit_minutes = (clock_ctl.edit_minutes >= MINUTE_MAX) ? 6'd0
				: clock_ctl.edit_minutes + 6'd1;
			mirror_edit();
		end
		if (down) begin
			clock_ctl.edit_minutes = (clock_ctl.edit_minutes == 6'd0) ? MINUTE_MAX
				: clock_ctl.edit_minutes - 6'd1;
			mirror_edit();
		end
	endfunction

	// Advance the controller by one poll; later checks override earlier ones.
	function automatic result_t mode_step(input item_t p);
		result_t r;
		r = '0;
		case (clock_ctl.mode)
			MODE_INIT: clock_ctl.mode = MODE_CLOCK;
			MODE_CLOCK: begin
				clock_ctl.shown_left  = p.now_minute;
				clock_ctl.shown_right = p.now_second;
				if (p.press_mode) begin
					clock_ctl.mode = MODE_ALARM;
					load_edit(clock_ctl.alarm_hours, clock_ctl.alarm_minutes);
					mirror_edit();
				end
				r.toggle_red = p.blink_red_due;
			end
			MODE_ALARM: begin
				if (p.press_mode) begin
					clock_ctl.mode = MODE_CD;
					load_edit(clock_ctl.preset_hours, clock_ctl.preset_minutes);
					mirror_edit();
				end
				// Set loads the alarm for editing but leaves the display alone.
				if (p.press_set) begin
					clock_ctl.mode = MODE_ALARM_HOUR;
					load_edit(clock_ctl.alarm_hours, clock_ctl.alarm_minutes);
				end
				r.toggle_yellow = p.blink_yellow_due;
			end
			MODE_ALARM_HOUR: begin
				r.toggle_green = p.blink_green_due;
				if (p.press_mode) clock_ctl.mode = MODE_CD;
				hour_buttons(p.press_up, p.press_down);
				if (p.press_set) begin
					clock_ctl.alarm_hours = clock_ctl.edit_hours;
					clock_ctl.mode        = MODE_ALARM_MIN;
				end
			end
			MODE_ALARM_MIN: begin
				if (p.press_mode) clock_ctl.mode = MODE_CD;
				minute_buttons(p.press_up, p.press_down);
				if (p.press_set) begin
					clock_ctl.alarm_minutes = clock_ctl.edit_minutes;
					clock_ctl.mode          = MODE_ALARM;
					clock_ctl.edit_hours    = clock_ctl.alarm_hours;
					mirror_edit();
				end
			end
			MODE_CD: begin
				if (p.press_mode) begin
					clock_ctl.mode = MODE_TIME;
					load_edit(p.now_hour, p.now_minute);
					mirror_edit();
				end
				if (p.press_set) begin
					clock_ctl.mode = MODE_CD_HOUR;
					load_edit(clock_ctl.preset_hours, clock_ctl.preset_minutes);
					mirror_edit();
				end
				if (p.press_up && p.press_down) begin
					clock_ctl.mode = MODE_CD_RUN;
					load_edit(clock_ctl.preset_hours, clock_ctl.preset_minutes);
					mirror_edit();
				end
			end
			MODE_CD_HOUR: begin
				if (p.press_mode) clock_ctl.mode = MODE_TIME;
				hour_buttons(p.press_up, p.press_down);
				if (p.press_set) begin
					clock_ctl.preset_hours = clock_ctl.edit_hours;
					clock_ctl.mode         = MODE_CD_MIN;
				end
			end
			MODE_CD_MIN: begin
				if (p.press_mode) clock_ctl.mode = MODE_TIME;
				minute_buttons(p.press_up, p.press_down);
				if (p.press_set) begin
					clock_ctl.preset_minutes = clock_ctl.edit_minutes;
					clock_ctl.mode           = MODE_CD;
					clock_ctl.edit_hours     = clock_ctl.preset_hours;
					mirror_edit();
				end
			end
			MODE_CD_RUN: begin
				// Count down with a borrow at zero minutes; 0:00 holds.
				if (p.countdown_tick) begin
					if (clock_ctl.edit_minutes != 6'd0) begin
						clock_ctl.edit_minutes = clock_ctl.edit_minutes - 6'd1;
					end else if (clock_ctl.edit_hours != 5'd0) begin
						clock_ctl.edit_hours   = clock_ctl.edit_hours - 5'd1;
						clock_ctl.edit_minutes = MINUTE_MAX;
					end
					mirror_edit();
				end
				if (p.press_mode) clock_ctl.mode = MODE_TIME;
				if (p.press_set) begin
					clock_ctl.preset_hours = clock_ctl.edit_hours;
					clock_ctl.mode         = MODE_CD_HOUR;
				end
			end
			MODE_TIME: begin
				if (p.press_mode) begin
					clock_ctl.mode = MODE_CLOCK;
					load_edit(p.now_hour, p.now_minute);
					mirror_edit();
				end
				if (p.press_set) clock_ctl.mode = MODE_TIME_HOUR;
			end
			MODE_TIME_HOUR: begin
				if (p.press_mode) clock_ctl.mode = MODE_CLOCK;
				hour_buttons(p.press_up, p.press_down);
				if (p.press_set) begin
					r.time_write_hour = 1'b1;
					r.new_hour        = clock_ctl.edit_hours;
					clock_ctl.mode    = MODE_TIME_MIN;
				end
			end
			MODE_TIME_MIN: begin
				if (p.press_mode) clock_ctl.mode = MODE_CLOCK;
				minute_buttons(p.press_up, p.press_down);
				// Leaving minute edit shows the hour of the external clock.
				if (p.press_set) begin
					r.time_write_minute  = 1'b1;
					r.new_minute         = clock_ctl.edit_minutes;
					clock_ctl.mode       = MODE_TIME;
					clock_ctl.edit_hours = p.now_hour;
					mirror_edit();
				end
			end
			default: ;
		endcase
		r.mode_code        = clock_ctl.mode;
		r.display_left     = clock_ctl.shown_left;
		r.display_right    = clock_ctl.shown_right;
		r.alarm_hour_out   = clock_ctl.alarm_hours;
		r.alarm_minute_out = clock_ctl.alarm_minutes;
		return r;
	endfunction

	// Random poll: mostly sparse button presses so the views get walked in depth,
	// with a share of dense button noise.
	function automatic item_t random_poll();
		item_t p;
		bit    noisy;
		noisy              = ($urandom_range(0, 9) == 0);
		p.press_mode       = noisy ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 5) == 0);
		p.press_set        = noisy ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 3) == 0);
		p.press_up         = noisy ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 2) == 0);
		p.press_down       = noisy ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 2) == 0);
		p.blink_red_due    = 1'($urandom_range(0, 1));
		p.blink_yellow_due = 1'($urandom_range(0, 1));
		p.blink_green_due  = 1'($urandom_range(0, 1));
		p.countdown_tick   = ($urandom_range(0, 9) < 7);
		p.now_hour         = 5'($urandom_range(0, 23));
		p.now_minute       = 6'($urandom_range(0, 59));
		p.now_second       = 6'($urandom_range(0, 59));
		return p;
	endfunction

	task automatic add_row(input item_t p, input bit typed, input result_t want);
		row_t r;
		r.poll  = p;
		r.typed = typed;
		r.want  = want;
		plan.push_back(r);
	endtask

	// Offer one poll, with random idle cycles ahead of it outside the steady stretch, and log its answer on acceptance.
	task automatic send_poll(input item_t p, input bit typed, input result_t want);
		result_t answer;
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pack_poll(p);
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		answer = mode_step(p);
		poll_answers.push_back(typed ? want : answer);
	endtask

	// Hold the sender off until every outstanding answer has come back.
	task automatic drain_answers();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (poll_answers.size() != 0);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			n_errors++;
		end
	endtask

	// Receiver: random stalls except in the steady stretch.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Scoreboard: every accepted result against the oldest expected answer.
	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = unpack_answer(m_axis_tdata);
			if (poll_answers.size() == 0) begin
				$error("result with no poll outstanding: %h", m_axis_tdata);
				n_errors++;
			end else begin
				want = poll_answers.pop_front();
				check_field("mode_code", want.mode_code, got.mode_code);
				check_field("display_left", want.display_left, got.display_left);
				check_field("display_right", want.display_right, got.display_right);
				check_field("toggle_red", want.toggle_red, got.toggle_red);
				check_field("toggle_yellow", want.toggle_yellow, got.toggle_yellow);
				check_field("toggle_green", want.toggle_green, got.toggle_green);
				check_field("time_write_hour", want.time_write_hour, got.time_write_hour);
				check_field("time_write_minute", want.time_write_minute,
					got.time_write_minute);
				check_field("new_hour", want.new_hour, got.new_hour);
				check_field("new_minute", want.new_minute, got.new_minute);
				check_field("alarm_hour_out", want.alarm_hour_out, got.alarm_hour_out);
				check_field("alarm_minute_out", want.alarm_minute_out,
					got.alarm_minute_out);
			end
		end
	end

	// Watchdog on cycles where neither side moves an item.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles = idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[clock_alarm_countdown_mode_fsm] ERROR");
			$finish;
		end
	end

	// Main sequence: reset, directed table, random polls, drain, verdict.
	initial begin
		int i;
		clock_ctl = '0;

		// Init to clock view, red blink in clock view, the alarm walk with its wraps.
		add_row(poll(B_NONE, D_NONE, 23, 59, 59), 1'b1, shown(MODE_CLOCK, 0, 0, 0, 0, 0));
		add_row(poll(B_NONE, D_RED, 23, 59, 59), 1'b1, shown(MODE_CLOCK, 59, 59, 0, 0, 1));
		add_row(poll(B_MODE, D_RED | D_YEL, 0, 0, 0), 1'b0, '0);
		add_row(poll(B_MODE | B_SET, D_YEL, 16, 32, 1), 1'b0, '0);
		add_row(poll(B_DOWN, D_GRE, 0, 0, 0), 1'b0, '0);
		add_row(poll(B_UP | B_DOWN, D_GRE, 0, 0, 0), 1'b0, '0);
		add_row(poll(B_SET, D_NONE, 0, 0, 0), 1'b0, '0);
		add_row(poll(B_DOWN, D_NONE, 0, 0, 0), 1'b0, '0);
		add_row(poll(B_SET, D_NONE, 0, 0, 0), 1'b1, shown(MODE_ALARM, 23, 59, 23, 59, 0));
		// Countdown preset 0:01, run it to 0:00 and hold there.
		add_row(poll(B_MODE, D_YEL, 0, 0, 0), 1'b0, '0);
		add_row(poll(B_SET, D_NONE, 0, 0, 0), 1'b0, '0);
		add_row(poll(B_SET, D_NONE, 0, 0, 0), 1'b0, '0);
		add_row(poll(B_UP, D_NONE, 0, 0, 0), 1'b0, '0);
		add_row(poll(B_SET, D_NONE, 0, 0, 0), 1'b0, '0);
		add_row(poll(B_UP | B_DOWN, D_NONE, 0, 0, 0), 1'b0, '0);
		add_row(poll(B_NONE, D_TICK, 0, 0, 0), 1'b0, '0);
		add_row(poll(B_NONE, D_TICK, 0, 0, 0), 1'b0, '0);
		// Preset 1:00 from the running view, then a borrow to 0:59.
		add_row(poll(B_SET, D_NONE, 0, 0, 0), 1'b0, '0);
		add_row(poll(B_UP, D_NONE, 0, 0, 0), 1'b0, '0);
		add_row(poll(B_SET, D_NONE, 0, 0, 0), 1'b0, '0);
		add_row(poll(B_SET, D_NONE, 0, 0, 0), 1'b0, '0);
		add_row(poll(B_UP | B_DOWN, D_NONE, 0, 0, 0), 1'b0, '0);
		add_row(poll(B_NONE, D_TICK, 0, 0, 0), 1'b0, '0);
		// Time setting: hour and minute strobes, then back to the clock view.
		add_row(poll(B_MODE, D_NONE, 0, 0, 0), 1'b0, '0);
		add_row(poll(B_SET, D_NONE, 0, 0, 0), 1'b0, '0);
		add_row(poll(B_DOWN, D_NONE, 0, 0, 0), 1'b0, '0);
		add_row(poll(B_SET, D_NONE, 0, 0, 0), 1'b0, '0);
		add_row(poll(B_UP, D_NONE, 0, 0, 0), 1'b0, '0);
		add_row(poll(B_SET, D_NONE, 16, 0, 0), 1'b0, '0);
		add_row(poll(B_MODE, D_NONE, 23, 59, 59), 1'b0, '0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) send_poll(plan[i].poll, plan[i].typed, plan[i].want);
		drain_answers();

		for (i = 0; i < RANDOM_POLLS; i++) begin
			if (i == 700) steady <= 1'b1;
			if (i == 1100) steady <= 1'b0;
			if (i == 1300) drain_answers();
			send_poll(random_poll(), 1'b0, '0);
		end

		s_axis_tvalid <= 1'b0;
		while (poll_answers.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (n_errors == 0) begin
			$display("[clock_alarm_countdown_mode_fsm] OK");
		end else begin
			$display("[clock_alarm_countdown_mode_fsm] ERROR");
		end
		$finish;
	end

endmodule
